// ===== hw/rtl/dsp_adpcm_frame_decoder_assert.svh =====
// Assertion macros for the ADPCM frame decoder.
`ifndef DSP_ADPCM_FRAME_DECODER_ASSERT_SVH
`define DSP_ADPCM_FRAME_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define ADPCM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ADPCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADPCM_ASSERT(lbl, clk, rst_n, prop, msg)
`define ADPCM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/adpcm_pkg.sv =====
package adpcm_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_W = 3;
	localparam int PRED_W = 3;
	localparam int PREDICTORS = 8;
	localparam int COEF_ROWS = MAX_CHANNELS * PREDICTORS;
	localparam int ROW_W = $clog2(COEF_ROWS);
	localparam int NIB_BITS = 56;
	localparam int FRAC_BITS = 11;
	localparam int ACC_W = 34;

	localparam logic [3:0] SAMPLES_PER_FRAME = 4'd14;
	localparam logic [ACC_W-1:0] ROUND = ACC_W'(1024);

	localparam logic [1:0] REQ_DECODE = 2'd0;
	localparam logic [1:0] REQ_LOAD_COEF = 2'd1;
	localparam logic [1:0] REQ_SET_HIST = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [CH_W-1:0]    channel;
		logic [63:0]        frame_bytes;
		logic [3:0]         num_samples;
		logic [PRED_W-1:0]  coef_index;
		logic signed [15:0] coef_first;
		logic signed [15:0] coef_second;
		logic signed [15:0] history_newest;
		logic signed [15:0] history_older;
	} req_t;

	typedef struct packed {
		logic signed [15:0] pcm_sample;
		logic [CH_W-1:0]    out_channel;
		logic [3:0]         sample_pos;
		logic               last;
	} smp_t;

	typedef struct packed {
		logic en;
		logic first;
	} mac_ctl_t;

endpackage

// ===== hw/rtl/dsp_adpcm_frame_decoder.sv =====
// ADPCM frame decoder for eight channels.
// Requests arrive on req_valid/req_ready/req_data, one beat per request. A decode
// request carries one 8-byte frame and yields one beat per sample on
// smp_valid/smp_ready/smp_data, with last set on the final sample of the frame.
// Load and set-history requests update a channel's coefficient pair or its history
// in the cycle they are taken and produce no output.
// A decode request occupies the block from the request cycle, which issues the coefficient
// RAM read, through a step that captures the coefficient pair and history, then per sample
// two passes through the single multiply-accumulate unit and an emit step that outputs the
// sample and shifts the history.
// The first sample reaches the output register after the COEF, MUL1, MUL2 and EMIT states.
// req_ready is high only while no frame is being decoded; a request that decodes
// no samples, or a load or set-history request, leaves the block idle and ready.
// When the receiver stalls, the decoder holds in its emit step until the output
// register frees, so no sample is lost or repeated.
// Reset marks all coefficient pairs unloaded, so they read as zero, clears histories
// to zero, empties the output register and leaves the block ready for a request.
`include "dsp_adpcm_frame_decoder_assert.svh"

module dsp_adpcm_frame_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  adpcm_pkg::req_t req_data,
	output logic            smp_valid,
	input  logic            smp_ready,
	output adpcm_pkg::smp_t smp_data
);
	import adpcm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COEF,
		ST_MUL1,
		ST_MUL2,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [CH_W-1:0]       ch_q;
	logic [3:0]            cnt_q;
	logic [3:0]            pos_q;
	logic [3:0]            shift_q;
	logic [NIB_BITS-1:0]   nib_q;
	logic signed [15:0]    c1_q;
	logic signed [15:0]    c2_q;
	logic signed [15:0]    h1_q;
	logic signed [15:0]    h2_q;
	logic                  coef_ok_q;
	logic                  smp_valid_q;
	smp_t                  smp_q;
	logic                  coef_vld_q [COEF_ROWS];
	logic signed [15:0]    hist_new_q [MAX_CHANNELS];
	logic signed [15:0]    hist_old_q [MAX_CHANNELS];

	logic                  accept;
	logic                  ch_ok;
	logic [3:0]            cnt_cap;
	logic                  ram_we;
	logic                  ram_re;
	logic [ROW_W-1:0]      ram_waddr;
	logic [ROW_W-1:0]      ram_raddr;
	logic [31:0]           ram_rdata;
	logic                  start;
	logic                  emit_go;
	logic                  last_flag;
	logic                  hist_set;
	mac_ctl_t              mac_ctl;
	logic signed [15:0]    mac_coef;
	logic signed [15:0]    mac_hist;
	logic signed [15:0]    sample;

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign ch_ok = 32'(req_data.channel) < MAX_CHANNELS;
	assign cnt_cap = (req_data.num_samples > SAMPLES_PER_FRAME) ?
		SAMPLES_PER_FRAME : req_data.num_samples;

	assign ram_we = accept && ch_ok && (req_data.req_type == REQ_LOAD_COEF);
	assign ram_re = accept && ch_ok && (req_data.req_type == REQ_DECODE);
	assign hist_set = accept && ch_ok && (req_data.req_type == REQ_SET_HIST);
	assign ram_waddr = {req_data.channel, req_data.coef_index};
	assign ram_raddr = {req_data.channel, req_data.frame_bytes[62:60]};
	assign start = ram_re && (cnt_cap != 4'd0);

	assign emit_go = (state_q == ST_EMIT) && (!smp_valid_q || smp_ready);
	assign last_flag = (4'(pos_q + 4'd1) == cnt_q);

	assign mac_ctl.en = (state_q == ST_MUL1) || (state_q == ST_MUL2);
	assign mac_ctl.first = (state_q == ST_MUL1);
	assign mac_coef = (state_q == ST_MUL1) ? c1_q : c2_q;
	assign mac_hist = (state_q == ST_MUL1) ? h1_q : h2_q;

	adpcm_ram #(
		.WIDTH(32),
		.DEPTH(COEF_ROWS)
	) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({req_data.coef_first, req_data.coef_second}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	adpcm_mac u_mac (
		.clk    (clk),
		.ctl    (mac_ctl),
		.nib    (nib_q[NIB_BITS-1 -: 4]),
		.shift  (shift_q),
		.coef   (mac_coef),
		.hist   (mac_hist),
		.sample (sample)
	);

	// A coefficient row that was never loaded reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_ROWS; i++) begin
				coef_vld_q[i] <= 1'b0;
			end
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				hist_new_q[i] <= '0;
				hist_old_q[i] <= '0;
			end
		end else begin
			if (ram_we) begin
				coef_vld_q[ram_waddr] <= 1'b1;
			end
			if (hist_set) begin
				hist_new_q[req_data.channel] <= req_data.history_newest;
				hist_old_q[req_data.channel] <= req_data.history_older;
			end else if (emit_go && last_flag) begin
				hist_new_q[ch_q] <= sample;
				hist_old_q[ch_q] <= h1_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			smp_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				smp_valid_q <= 1'b1;
			end else if (smp_ready) begin
				smp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_COEF;
					end
				end
				ST_COEF: begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= last_flag ? ST_IDLE : ST_MUL1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ch_q <= req_data.channel;
			cnt_q <= cnt_cap;
			pos_q <= 4'd0;
			shift_q <= req_data.frame_bytes[59:56];
			nib_q <= req_data.frame_bytes[NIB_BITS-1:0];
			coef_ok_q <= coef_vld_q[ram_raddr];
		end
		if (state_q == ST_COEF) begin
			c1_q <= coef_ok_q ? ram_rdata[31:16] : '0;
			c2_q <= coef_ok_q ? ram_rdata[15:0] : '0;
			h1_q <= hist_new_q[ch_q];
			h2_q <= hist_old_q[ch_q];
		end
		if (emit_go) begin
			smp_q.pcm_sample <= sample;
			smp_q.out_channel <= ch_q;
			smp_q.sample_pos <= pos_q;
			smp_q.last <= last_flag;
			h1_q <= sample;
			h2_q <= h1_q;
			nib_q <= {nib_q[NIB_BITS-5:0], 4'd0};
			pos_q <= 4'(pos_q + 4'd1);
		end
	end

	assign smp_valid = smp_valid_q;
	assign smp_data = smp_q;

	`ADPCM_ASSERT(a_pos_in_range, clk, arst_n, (state_q == ST_EMIT) |-> (pos_q < cnt_q), "sample position beyond frame count")
	`ADPCM_ASSERT(a_coef_after_read, clk, arst_n, (state_q == ST_COEF) |-> $past(ram_re), "coefficient fetch without RAM read")
	`ADPCM_ASSERT(a_idle_after_last, clk, arst_n, (emit_go && last_flag) |=> (state_q == ST_IDLE), "decoder busy after last sample")
	`ADPCM_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> (state_q == ST_IDLE && !smp_valid_q), "reset does not clear control state")

endmodule

// ===== hw/rtl/adpcm_ram.sv =====
module adpcm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/adpcm_mac.sv =====
module adpcm_mac (
	input  logic                 clk,
	input  adpcm_pkg::mac_ctl_t  ctl,
	input  logic [3:0]           nib,
	input  logic [3:0]           shift,
	input  logic signed [15:0]   coef,
	input  logic signed [15:0]   hist,
	output logic signed [15:0]   sample
);
	import adpcm_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] base;
	logic signed [31:0]      prod;
	logic signed [ACC_W-1:0] quot;
	logic [4:0]              amount;

	// The first step of a sample seeds the sum with the scaled nibble and rounding term.
	assign amount = {1'b0, shift} + 5'(FRAC_BITS);
	assign base = (ACC_W'(signed'(nib)) <<< amount) + signed'(ROUND);
	assign prod = coef * hist;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= (ctl.first ? base : acc_q) + ACC_W'(prod);
		end
	end

	assign quot = acc_q >>> FRAC_BITS;

	always_comb begin
		if (quot > SAT_MAX) begin
			sample = 16'sh7fff;
		end else if (quot < SAT_MIN) begin
			sample = -16'sh8000;
		end else begin
			sample = quot[15:0];
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import adpcm_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 130;

	typedef struct {
		req_t req;
		bit   typed;
		int   first_pcm;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic smp_valid;
	logic smp_ready = 1'b0;
	smp_t smp_data;

	logic signed [15:0] coef_newest_w [MAX_CHANNELS][PREDICTORS];
	logic signed [15:0] coef_older_w [MAX_CHANNELS][PREDICTORS];
	logic signed [15:0] hist_new [MAX_CHANNELS];
	logic signed [15:0] hist_old [MAX_CHANNELS];

	smp_t frame_samples[$];
	smp_t pending_samples[$];
	row_t plan[$];

	bit no_idle = 1'b0;
	int n_errors = 0;
	int n_checked = 0;
	int n_decodes = 0;
	int n_loads = 0;
	int n_hist_sets = 0;
	int n_ignored = 0;

	dsp_adpcm_frame_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.smp_valid(smp_valid),
		.smp_ready(smp_ready),
		.smp_data(smp_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int idle_draw();
		return no_idle ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic req_t mk(logic [1:0] kind, logic [2:0] ch, logic [63:0] frame,
			logic [3:0] cnt, logic [2:0] idx, int ca, int cb, int ha, int hb);
		req_t r;
		r.req_type = kind;
		r.channel = ch;
		r.frame_bytes = frame;
		r.num_samples = cnt;
		r.coef_index = idx;
		r.coef_first = 16'(ca);
		r.coef_second = 16'(cb);
		r.history_newest = 16'(ha);
		r.history_older = 16'(hb);
		return r;
	endfunction

	function automatic void decode_model(req_t r);
		logic [3:0] n;
		logic [7:0] hdr;
		logic signed [3:0] nib4;
		longint c1, c2, h1, h2, nib, acc, v;
		smp_t s;
		frame_samples.delete();
		case (r.req_type)
			REQ_LOAD_COEF: begin
				coef_newest_w[r.channel][r.coef_index] = r.coef_first;
				coef_older_w[r.channel][r.coef_index] = r.coef_second;
				n_loads++;
			end
			REQ_SET_HIST: begin
				hist_new[r.channel] = r.history_newest;
				hist_old[r.channel] = r.history_older;
				n_hist_sets++;
			end
			REQ_DECODE: begin
				n = (r.num_samples > SAMPLES_PER_FRAME) ? SAMPLES_PER_FRAME : r.num_samples;
				hdr = r.frame_bytes[63:56];
				c1 = longint'(coef_newest_w[r.channel][hdr[6:4]]);
				c2 = longint'(coef_older_w[r.channel][hdr[6:4]]);
				h1 = longint'(hist_new[r.channel]);
				h2 = longint'(hist_old[r.channel]);
				for (int i = 0; i < n; i++) begin
					nib4 = r.frame_bytes[(13 - i) * 4 +: 4];
					nib = longint'(nib4);
					acc = ((nib <<< hdr[3:0]) <<< 11) + 1024 + c1 * h1 + c2 * h2;
					v = acc >>> 11;
					if (v < -32768)
						v = -32768;
					if (v > 32767)
						v = 32767;
					h2 = h1;
					h1 = v;
					s.pcm_sample = 16'(v);
					s.out_channel = r.channel;
					s.sample_pos = 4'(i);
					s.last = (i == n - 1);
					frame_samples.push_back(s);
				end
				hist_new[r.channel] = 16'(h1);
				hist_old[r.channel] = 16'(h2);
				n_decodes++;
			end
			default: begin
				n_ignored++;
			end
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("Mismatch at %0t: %s", $time, msg);
		n_errors++;
	endtask

	task automatic send_req(req_t r, bit typed, int first_pcm);
		int gap;
		smp_t s;
		gap = idle_draw();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_data <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		decode_model(r);
		if (typed && frame_samples.size() > 0) begin
			s = frame_samples[0];
			s.pcm_sample = 16'(first_pcm);
			frame_samples[0] = s;
		end
		foreach (frame_samples[i])
			pending_samples.push_back(frame_samples[i]);
	endtask

	task automatic drain_pause();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
	endtask

	function automatic req_t random_req();
		req_t r;
		logic [159:0] raw;
		int pick;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 6)
			r.req_type = REQ_UNUSED;
		else if (pick < 20) begin
			r.req_type = REQ_LOAD_COEF;
			if ($urandom_range(0, 1)) begin
				r.coef_first = 16'($urandom_range(0, 4096));
				r.coef_second = -16'($urandom_range(0, 2048));
			end
		end else if (pick < 32) begin
			r.req_type = REQ_SET_HIST;
			if ($urandom_range(0, 1)) begin
				r.history_newest = 16'($urandom_range(0, 4000)) - 16'sd2000;
				r.history_older = 16'($urandom_range(0, 4000)) - 16'sd2000;
			end
		end else begin
			r.req_type = REQ_DECODE;
			if ($urandom_range(0, 9) < 7)
				r.num_samples = SAMPLES_PER_FRAME;
			if ($urandom_range(0, 1))
				r.frame_bytes[59:56] = 4'($urandom_range(0, 11));
		end
		return r;
	endfunction

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = idle_draw();
			@(negedge clk);
			if (stall > 0) begin
				smp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			smp_ready <= 1'b1;
			do @(posedge clk); while (!(smp_valid && smp_ready));
		end
	end

	always @(posedge clk) begin
		smp_t want;
		if (arst_n && smp_valid && smp_ready) begin
			if (pending_samples.size() == 0)
				report_mismatch($sformatf("unexpected sample beat %p", smp_data));
			else begin
				want = pending_samples.pop_front();
				n_checked++;
				if (smp_data.pcm_sample !== want.pcm_sample ||
						smp_data.out_channel !== want.out_channel ||
						smp_data.sample_pos !== want.sample_pos ||
						smp_data.last !== want.last)
					report_mismatch($sformatf("got %p, expected %p", smp_data, want));
			end
		end
	end

	initial begin
		int items;
		bit paused;
		foreach (coef_newest_w[c, p]) begin
			coef_newest_w[c][p] = '0;
			coef_older_w[c][p] = '0;
		end
		foreach (hist_new[c]) begin
			hist_new[c] = '0;
			hist_old[c] = '0;
		end

		plan = '{
			'{mk(REQ_DECODE, 3'd0, 64'h0C71_2345_6789_ABCD, 4'd14, 3'd0, 0, 0, 0, 0), 1'b1, 28672},
			'{mk(REQ_DECODE, 3'd1, 64'h0F7F_0000_0000_0000, 4'd1, 3'd0, 0, 0, 0, 0), 1'b1, 32767},
			'{mk(REQ_DECODE, 3'd2, 64'h0F80_0000_0000_0000, 4'd14, 3'd0, 0, 0, 0, 0), 1'b1, -32768},
			'{mk(REQ_DECODE, 3'd3, 64'h00F7_7777_7777_7777, 4'd15, 3'd0, 0, 0, 0, 0), 1'b1, -1},
			'{mk(REQ_DECODE, 3'd4, 64'h1234_5678_9ABC_DEF0, 4'd0, 3'd0, 0, 0, 0, 0), 1'b0, 0},
			'{mk(REQ_UNUSED, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd14, 3'd7, 1, 1, 1, 1), 1'b0, 0},
			'{mk(REQ_LOAD_COEF, 3'd0, 64'h0, 4'd0, 3'd0, 32767, -32768, 0, 0), 1'b0, 0},
			'{mk(REQ_LOAD_COEF, 3'd0, 64'h0, 4'd0, 3'd7, -32768, 32767, 0, 0), 1'b0, 0},
			'{mk(REQ_SET_HIST, 3'd0, 64'h0, 4'd0, 3'd0, 0, 0, 32767, -32768), 1'b0, 0},
			'{mk(REQ_DECODE, 3'd0, 64'h0012_3456_789A_BCDE, 4'd14, 3'd0, 0, 0, 0, 0), 1'b0, 0},
			'{mk(REQ_DECODE, 3'd0, 64'hF38F_E1D2_C3B4_A596, 4'd14, 3'd0, 0, 0, 0, 0), 1'b0, 0},
			'{mk(REQ_SET_HIST, 3'd5, 64'h0, 4'd0, 3'd0, 0, 0, -32768, -32768), 1'b0, 0},
			'{mk(REQ_LOAD_COEF, 3'd5, 64'h0, 4'd0, 3'd3, -32768, -32768, 0, 0), 1'b0, 0},
			'{mk(REQ_DECODE, 3'd5, 64'h3B70_8F19_2A6E_5C4D, 4'd14, 3'd0, 0, 0, 0, 0), 1'b0, 0},
			'{mk(REQ_LOAD_COEF, 3'd7, 64'h0, 4'd0, 3'd2, 4096, -2048, 0, 0), 1'b0, 0},
			'{mk(REQ_SET_HIST, 3'd7, 64'h0, 4'd0, 3'd0, 0, 0, 1000, -500), 1'b0, 0},
			'{mk(REQ_DECODE, 3'd7, 64'hA412_3F0E_D7C8_B9A6, 4'd9, 3'd0, 0, 0, 0, 0), 1'b0, 0},
			'{mk(REQ_DECODE, 3'd7, 64'h2433_2211_00FF_EEDD, 4'd14, 3'd0, 0, 0, 0, 0), 1'b0, 0},
			'{mk(REQ_DECODE, 3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 4'd14, 3'd7, -1, -1, -1, -1),
				1'b0, 0},
			'{mk(REQ_DECODE, 3'd6, 64'h0000_0000_0000_0000, 4'd14, 3'd0, 0, 0, 0, 0), 1'b0, 0},
			'{mk(REQ_DECODE, 3'd0, 64'h7C77_7777_7777_7777, 4'd1, 3'd0, 0, 0, 0, 0), 1'b0, 0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			send_req(plan[i].req, plan[i].typed, plan[i].first_pcm);
		drain_pause();

		items = 0;
		paused = 1'b0;
		while (items < RANDOM_ITEMS) begin
			no_idle = ((items / 25) % 2) == 1;
			if (items == RANDOM_ITEMS / 2 && !paused) begin
				drain_pause();
				paused = 1'b1;
			end
			req_data_loop: begin
				req_t r;
				r = random_req();
				send_req(r, 1'b0, 0);
				items++;
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Run covered %0d frame decodes, %0d coefficient loads,", n_decodes, n_loads);
		$display("%0d history sets, %0d ignored requests and %0d sample beats, %0d mismatches.",
			n_hist_sets, n_ignored, n_checked, n_errors);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/adpcm_pkg.sv
hw/rtl/adpcm_ram.sv
hw/rtl/adpcm_mac.sv
hw/rtl/dsp_adpcm_frame_decoder.sv
bench/tb_top.sv
